/* rtl/pres_pkg.sv */
// Shared types, command codes and arithmetic step functions for the
// position ring speed estimator. No dependencies.
package pres_pkg;

  localparam int ROOT_W = 34;   // root of a 68-bit radicand, one bit per pair
  localparam int REM_W  = 36;   // square root partial remainder

  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [31:0] ACCEL_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ACCEL_NEG_MAG = 32'h8000_0000;

  // iteration counts, two result bits per cycle
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] ROOT_STEPS = 5'd17;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd16;

  // datapath operation codes
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_ABS  = 4'd2;
  localparam logic [3:0] OP_SQX  = 4'd3;
  localparam logic [3:0] OP_SQY  = 4'd4;
  localparam logic [3:0] OP_SUM  = 4'd5;
  localparam logic [3:0] OP_ROOT = 4'd6;
  localparam logic [3:0] OP_MULS = 4'd7;
  localparam logic [3:0] OP_DIVI = 4'd8;
  localparam logic [3:0] OP_DIV  = 4'd9;
  localparam logic [3:0] OP_SPD  = 4'd10;
  localparam logic [3:0] OP_DIFF = 4'd11;
  localparam logic [3:0] OP_ABSD = 4'd12;
  localparam logic [3:0] OP_MULA = 4'd13;
  localparam logic [3:0] OP_ACC  = 4'd14;
  localparam logic [3:0] OP_OUT  = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic       ring_load;    // write sample into ring (seed on first)
    logic       ring_commit;  // store speed, advance pointer
  } pres_cmd_t;

  typedef struct packed {
    logic dt_zero;
  } pres_status_t;

  // one ring entry as read at the oldest position
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
    logic [31:0] s;
  } pres_entry_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } pres_sqrt_t;

  typedef struct packed {
    logic        q;
    logic [31:0] rem;
  } pres_div_t;

  // one restoring square root step on the next radicand bit pair
  function automatic pres_sqrt_t sqrt_step(pres_sqrt_t s, logic [1:0] pair);
    pres_sqrt_t  r;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    cur   = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = REM_W'(cur - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one restoring division step; rem stays below den
  function automatic pres_div_t div_step(logic [31:0] rem, logic b, logic [31:0] den);
    pres_div_t  r;
    logic [32:0] cur;
    cur = {rem, b};
    if (cur >= {1'b0, den}) begin
      r.q   = 1'b1;
      r.rem = 32'(cur - {1'b0, den});
    end else begin
      r.q   = 1'b0;
      r.rem = cur[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/pres_if.sv */
// Stream channel interfaces: position samples in, estimates out.
// No dependencies.
interface pres_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;     // signed Q16.16
  logic [31:0] pos_y;     // signed Q16.16
  logic [31:0] stamp_us;

  modport source (output valid, pos_x, pos_y, stamp_us, input ready);
  modport sink   (input valid, pos_x, pos_y, stamp_us, output ready);
endinterface

interface pres_estimate_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed;     // unsigned Q16.16
  logic [31:0] accel;     // signed Q16.16
  logic        estimate_valid;

  modport source (output valid, speed, accel, estimate_valid, input ready);
  modport sink   (input valid, speed, accel, estimate_valid, output ready);
endinterface

/* rtl/pres_ring.sv */
// Sample ring: positions, times and speeds of the last DEPTH samples,
// write pointer and first-sample seeding. Uses pres_pkg.
module pres_ring import pres_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  pres_cmd_t   cmd,
  input  logic [31:0] wr_x,
  input  logic [31:0] wr_y,
  input  logic [31:0] wr_t,
  input  logic [31:0] wr_s,
  output pres_entry_t old_entry
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [31:0] x_mem [DEPTH];
  logic [31:0] y_mem [DEPTH];
  logic [31:0] t_mem [DEPTH];
  logic [31:0] s_mem [DEPTH];

  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] old_ptr;
  logic             seeded;

  assign old_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;

  // before seeding every entry reads as the seed values
  always_comb begin
    if (seeded) begin
      old_entry.x = x_mem[old_ptr];
      old_entry.y = y_mem[old_ptr];
      old_entry.t = t_mem[old_ptr];
      old_entry.s = s_mem[old_ptr];
    end else begin
      old_entry.x = '0;
      old_entry.y = '0;
      old_entry.t = wr_t;
      old_entry.s = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      seeded <= 1'b0;
    end else begin
      if (cmd.ring_load) begin
        seeded <= 1'b1;
      end
      if (cmd.ring_commit) begin
        ptr <= old_ptr;
      end
    end
  end

  // the entry at the pointer takes the sample; on the first load the
  // others take the seed
  always_ff @(posedge clk) begin
    if (cmd.ring_load) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (PTR_W'(i) == ptr) begin
          x_mem[i] <= wr_x;
          y_mem[i] <= wr_y;
          t_mem[i] <= wr_t;
        end else if (!seeded) begin
          x_mem[i] <= '0;
          y_mem[i] <= '0;
          t_mem[i] <= wr_t;
          s_mem[i] <= '0;
        end
      end
    end
    if (cmd.ring_commit) begin
      s_mem[ptr] <= wr_s;
    end
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(DEPTH - 1))
    else $error("ring pointer out of range");
`endif

endmodule

/* rtl/pres_dp.sv */
// Arithmetic datapath: differences, squares, shared-step square root,
// divider and saturation, plus the output register. Uses pres_pkg.
module pres_dp import pres_pkg::*; (
  input  logic         clk,
  input  pres_cmd_t    cmd,
  input  logic [31:0]  in_x,
  input  logic [31:0]  in_y,
  input  logic [31:0]  in_t,
  input  pres_entry_t  old_entry,
  output pres_status_t status,
  output logic [31:0]  commit_speed,
  output logic [31:0]  out_speed,
  output logic [31:0]  out_accel,
  output logic         out_est_valid
);

  logic [32:0] dx, dy;        // signed differences
  logic [32:0] ax, ay;        // magnitudes
  logic [31:0] dt;
  logic [31:0] s_old;
  logic        dt_zero;
  logic [65:0] sq;
  logic [65:0] prod;
  logic [67:0] rad;
  pres_sqrt_t  sr;
  logic [53:0] num;
  logic        sat;
  logic [31:0] drem, dnum, quot;
  logic [31:0] speed_r, accel_r;
  logic [32:0] diff;
  logic [31:0] mag;
  logic        neg;

  pres_sqrt_t s1, s2;
  pres_div_t  d1, d2;
  logic [31:0] q_lim;

  always_comb begin
    s1 = sqrt_step(sr, rad[67:66]);
    s2 = sqrt_step(s1, rad[65:64]);
    d1 = div_step(drem, dnum[31], dt);
    d2 = div_step(d1.rem, dnum[30], dt);
    if (neg) begin
      q_lim = (sat || quot > ACCEL_NEG_MAG) ? ACCEL_NEG_MAG : quot;
    end else begin
      q_lim = (sat || quot > ACCEL_POS_MAX) ? ACCEL_POS_MAX : quot;
    end
  end

  assign status.dt_zero = dt_zero;
  assign commit_speed   = dt_zero ? '0 : speed_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dx      <= {in_x[31], in_x} - {old_entry.x[31], old_entry.x};
        dy      <= {in_y[31], in_y} - {old_entry.y[31], old_entry.y};
        dt      <= in_t - old_entry.t;
        dt_zero <= (in_t == old_entry.t);
        s_old   <= old_entry.s;
      end
      OP_ABS: begin
        ax <= dx[32] ? 33'd0 - dx : dx;
        ay <= dy[32] ? 33'd0 - dy : dy;
      end
      OP_SQX: sq   <= ax * ax;
      OP_SQY: prod <= ay * ay;
      OP_SUM: begin
        rad <= 68'(sq) + 68'(prod);
        sr  <= '0;
      end
      OP_ROOT: begin
        sr  <= s2;
        rad <= {rad[63:0], 4'b0000};
      end
      OP_MULS: num <= sr.root * US_PER_S;
      OP_DIVI: begin
        // quotient reaches 2^32 exactly when the high part reaches dt
        sat  <= ({10'b0, num[53:32]} >= dt);
        drem <= ({10'b0, num[53:32]} >= dt) ? '0 : {10'b0, num[53:32]};
        dnum <= num[31:0];
        quot <= '0;
      end
      OP_DIV: begin
        drem <= d2.rem;
        dnum <= {dnum[29:0], 2'b00};
        quot <= {quot[29:0], d1.q, d2.q};
      end
      OP_SPD:  speed_r <= sat ? 32'hFFFF_FFFF : quot;
      OP_DIFF: diff    <= {1'b0, speed_r} - {1'b0, s_old};
      OP_ABSD: begin
        mag <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
        neg <= diff[32];
      end
      OP_MULA: num     <= mag * US_PER_S;
      OP_ACC:  accel_r <= neg ? 32'd0 - q_lim : q_lim;
      OP_OUT: begin
        out_speed     <= dt_zero ? '0 : speed_r;
        out_accel     <= dt_zero ? '0 : accel_r;
        out_est_valid <= !dt_zero;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pres_ctrl.sv */
// Sequencer: walks the datapath through one estimate, holds the
// output-valid flag and the channel handshakes. Uses pres_pkg.
module pres_ctrl import pres_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  pres_status_t status,
  output pres_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ABS   = 5'd1;
  localparam logic [4:0] S_SQX   = 5'd2;
  localparam logic [4:0] S_SQY   = 5'd3;
  localparam logic [4:0] S_SUM   = 5'd4;
  localparam logic [4:0] S_ROOT  = 5'd5;
  localparam logic [4:0] S_MULS  = 5'd6;
  localparam logic [4:0] S_DIVSI = 5'd7;
  localparam logic [4:0] S_DIVS  = 5'd8;
  localparam logic [4:0] S_SPD   = 5'd9;
  localparam logic [4:0] S_DIFF  = 5'd10;
  localparam logic [4:0] S_ABSD  = 5'd11;
  localparam logic [4:0] S_MULA  = 5'd12;
  localparam logic [4:0] S_DIVAI = 5'd13;
  localparam logic [4:0] S_DIVA  = 5'd14;
  localparam logic [4:0] S_ACC   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    cnt_next        = '0;
    cmd.op          = OP_NONE;
    cmd.ring_load   = 1'b0;
    cmd.ring_commit = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op        = OP_LOAD;
          cmd.ring_load = 1'b1;
          state_next    = S_ABS;
        end
      end
      S_ABS: begin
        cmd.op     = OP_ABS;
        state_next = status.dt_zero ? S_OUT : S_SQX;
      end
      S_SQX: begin
        cmd.op     = OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (cnt == ROOT_STEPS - 1'b1) begin
          state_next = S_MULS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MULS: begin
        cmd.op     = OP_MULS;
        state_next = S_DIVSI;
      end
      S_DIVSI: begin
        cmd.op     = OP_DIVI;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.op = OP_DIV;
        if (cnt == DIV_STEPS - 1'b1) begin
          state_next = S_SPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SPD: begin
        cmd.op     = OP_SPD;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_ABSD;
      end
      S_ABSD: begin
        cmd.op     = OP_ABSD;
        state_next = S_MULA;
      end
      S_MULA: begin
        cmd.op     = OP_MULA;
        state_next = S_DIVAI;
      end
      S_DIVAI: begin
        cmd.op     = OP_DIVI;
        state_next = S_DIVA;
      end
      S_DIVA: begin
        cmd.op = OP_DIV;
        if (cnt == DIV_STEPS - 1'b1) begin
          state_next = S_ACC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_OUT;
      end
      S_OUT: begin
        // result register free, or emptied in this same cycle
        if (!out_valid || out_ready) begin
          cmd.op          = OP_OUT;
          cmd.ring_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> !out_valid || out_ready)
    else $error("pending estimate overwritten");
  a_out_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |=> out_valid)
    else $error("estimate not presented after output load");
  a_zero_dt_skip: assert property (@(posedge clk) disable iff (rst)
    state == S_ABS && status.dt_zero |=> state == S_OUT)
    else $error("zero interval did not skip arithmetic");
  a_root_count: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT |-> cnt < ROOT_STEPS)
    else $error("root iteration count overrun");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.ring_commit |=> state == S_IDLE && !cmd.ring_commit)
    else $error("ring commit outside end of item");
`endif

endmodule

/* rtl/position_ring_speed_estimator.sv */
// Top level of the position ring speed estimator: controller, datapath
// and sample ring. Uses pres_pkg and the interfaces in pres_if.sv.
//
// Usage:
//   sample   : valid/ready sink; one transfer is one timestamped position
//              (pos_x, pos_y signed Q16.16 m; stamp_us in microseconds).
//   estimate : valid/ready source; one transfer per sample with speed
//              (unsigned Q16.16 m/s), accel (signed Q16.16 m/s^2) and
//              estimate_valid (low when the interval is zero).
//   Speed uses the distance and interval to the oldest of RING_DEPTH
//   samples; accel uses the difference to that entry's stored speed.
//   One sample at a time. From sample transfer to estimate valid the
//   sample runs a square root (two root bits per cycle), two divisions
//   on a shared two-bit-per-cycle divider, plus setup, multiply and
//   saturation steps. A zero interval (always the first sample after
//   reset) skips the squares, root and divisions and goes to the output step.
//   The estimate sits in an output register, so a new sample is taken
//   while it waits; a stalled receiver only holds the next estimate back
//   at its final step. Reset empties the output and unseeds the ring; the
//   first sample fills the pointer entry and gives every other entry its
//   time, zero position and zero speed. No clearing pass.
module position_ring_speed_estimator import pres_pkg::*; #(
  parameter int RING_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  pres_sample_if.sink     sample,
  pres_estimate_if.source estimate
);

  pres_cmd_t    cmd;
  pres_status_t status;
  pres_entry_t  old_entry;
  logic [31:0]  commit_speed;

  pres_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (estimate.valid),
    .out_ready (estimate.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath sees the sample payload only during the load step
  pres_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_x          (sample.pos_x),
    .in_y          (sample.pos_y),
    .in_t          (sample.stamp_us),
    .old_entry     (old_entry),
    .status        (status),
    .commit_speed  (commit_speed),
    .out_speed     (estimate.speed),
    .out_accel     (estimate.accel),
    .out_est_valid (estimate.estimate_valid)
  );

  // ring writes position and time at load, speed at commit
  pres_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_x      (sample.pos_x),
    .wr_y      (sample.pos_y),
    .wr_t      (sample.stamp_us),
    .wr_s      (commit_speed),
    .old_entry (old_entry)
  );

endmodule
